// ===== rtl/cwb_pkg.sv =====
package cwb_pkg;

  localparam int STORE_LEN_DEF = 64;

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 7;
  localparam int VAL_W  = 32;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PARSE = 2'd2;

  localparam logic [CHAR_W-1:0] FILL_BYTE  = 8'h00;
  localparam logic [CHAR_W-1:0] SPACE_BYTE = 8'h20;
  localparam logic [CHAR_W-1:0] MINUS_BYTE = 8'h2D;
  localparam logic [CHAR_W-1:0] DIGIT_LO   = 8'h30;
  localparam logic [CHAR_W-1:0] DIGIT_HI   = 8'h39;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_in;
    logic [IDX_W-1:0]  word_index;
  } in_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] int_value;
    logic                    is_full;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic clear;
    logic query;
    logic other;
    logic scan;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic term;
  } dp_stat_t;

endpackage

// ===== rtl/cwb_ctrl.sv =====
module cwb_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cwb_pkg::FUNC_W-1:0]   func,
  input  cwb_pkg::dp_stat_t            stat,
  output cwb_pkg::ctrl_cmd_t           cmd,
  output logic                         busy,
  output logic                         out_strobe
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic strobe_r, strobe_nxt;
  logic accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.push  = accept && (func == cwb_pkg::FUNC_PUSH);
    cmd.clear = accept && (func == cwb_pkg::FUNC_CLEAR);
    cmd.query = accept && (func == cwb_pkg::FUNC_PARSE);
    cmd.other = accept && !cmd.push && !cmd.clear && !cmd.query;
    cmd.scan  = (state_r == ST_SCAN);
  end

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd.query) begin
          state_nxt = ST_SCAN;
        end else if (accept) begin
          strobe_nxt = 1'b1;
        end
      end
      ST_SCAN: begin
        if (stat.term) begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;

endmodule

// ===== rtl/cwb_dp.sv =====
module cwb_dp #(
  parameter int STORE_LEN = cwb_pkg::STORE_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cwb_pkg::in_t        in_data,
  input  cwb_pkg::ctrl_cmd_t  cmd,
  output cwb_pkg::dp_stat_t   stat,
  output cwb_pkg::out_t       out_data
);

  localparam int ADDR_W = (STORE_LEN > 1) ? $clog2(STORE_LEN) : 1;
  localparam int CNT_W  = $clog2(STORE_LEN + 1);
  localparam int CMP_W  = (CNT_W > cwb_pkg::IDX_W) ? CNT_W : cwb_pkg::IDX_W;
  localparam int VAL_W  = cwb_pkg::VAL_W;

  logic [cwb_pkg::CHAR_W-1:0] mem [STORE_LEN];
  logic [cwb_pkg::CHAR_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]          rd_addr;

  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic                       full;
  logic [cwb_pkg::CHAR_W-1:0] push_byte;

  logic [cwb_pkg::IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]           pos_r, pos_nxt;
  logic [CNT_W-1:0]           wcnt_r, wcnt_nxt;
  logic                       prev_fill_r, prev_fill_nxt;
  logic                       in_tgt_r, in_tgt_nxt;
  logic                       neg_r, neg_nxt;
  logic                       any_r, any_nxt;
  logic [VAL_W-1:0]           acc_r, acc_nxt;

  logic [cwb_pkg::CHAR_W-1:0] cur_byte;
  logic [cwb_pkg::CHAR_W-1:0] digit_off;
  logic                       is_digit;
  logic                       at_end;
  logic [VAL_W-1:0]           acc_step;
  logic [VAL_W-1:0]           digit_ext;
  logic                       term;
  logic                       pass;
  logic [VAL_W-1:0]           final_val;

  cwb_pkg::out_t              out_r;

  assign full      = (fill_r == CNT_W'(STORE_LEN));
  assign push_byte = (in_data.char_in == cwb_pkg::SPACE_BYTE) ? cwb_pkg::FILL_BYTE
                                                              : in_data.char_in;

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.clear) begin
      fill_nxt = '0;
    end else if (cmd.push && !full) begin
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  // read one position ahead of the byte being examined
  assign rd_addr = cmd.scan ? pos_nxt[ADDR_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[fill_r[ADDR_W-1:0]] <= push_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  // positions past the fill count read as fill
  assign at_end    = (pos_r >= fill_r);
  assign cur_byte  = at_end ? cwb_pkg::FILL_BYTE : rd_data_r;
  assign is_digit  = (cur_byte >= cwb_pkg::DIGIT_LO) && (cur_byte <= cwb_pkg::DIGIT_HI);
  assign digit_off = cur_byte - cwb_pkg::DIGIT_LO;
  assign digit_ext = {{(VAL_W-4){1'b0}}, digit_off[3:0]};
  assign acc_step  = {acc_r[VAL_W-4:0], 3'b000} + {acc_r[VAL_W-2:0], 1'b0} + digit_ext;

  always_comb begin
    pos_nxt       = pos_r + CNT_W'(1);
    wcnt_nxt      = wcnt_r;
    prev_fill_nxt = prev_fill_r;
    in_tgt_nxt    = in_tgt_r;
    neg_nxt       = neg_r;
    any_nxt       = any_r;
    acc_nxt       = acc_r;
    term          = 1'b0;
    pass          = 1'b0;
    if (in_tgt_r) begin
      if (cur_byte == cwb_pkg::FILL_BYTE) begin
        term = 1'b1;
        pass = any_r;
      end else if (is_digit) begin
        acc_nxt = acc_step;
        any_nxt = 1'b1;
      end else begin
        term = 1'b1;
      end
    end else if (cur_byte == cwb_pkg::FILL_BYTE) begin
      prev_fill_nxt = 1'b1;
      term          = at_end;
    end else begin
      prev_fill_nxt = 1'b0;
      if (prev_fill_r) begin
        if (CMP_W'(wcnt_r) == CMP_W'(idx_r)) begin
          in_tgt_nxt = 1'b1;
          if (cur_byte == cwb_pkg::MINUS_BYTE) begin
            neg_nxt = 1'b1;
          end else if (is_digit) begin
            acc_nxt = digit_ext;
            any_nxt = 1'b1;
          end else begin
            term = 1'b1;
          end
        end else begin
          wcnt_nxt = wcnt_r + CNT_W'(1);
        end
      end
    end
  end

  assign final_val = neg_r ? (VAL_W'(0) - acc_r) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      idx_r       <= in_data.word_index;
      pos_r       <= '0;
      wcnt_r      <= '0;
      prev_fill_r <= 1'b1;
      in_tgt_r    <= 1'b0;
      neg_r       <= 1'b0;
      any_r       <= 1'b0;
      acc_r       <= '0;
    end else if (cmd.scan) begin
      pos_r       <= pos_nxt;
      wcnt_r      <= wcnt_nxt;
      prev_fill_r <= prev_fill_nxt;
      in_tgt_r    <= in_tgt_nxt;
      neg_r       <= neg_nxt;
      any_r       <= any_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_r.ok        <= !full;
      out_r.int_value <= '0;
      out_r.is_full   <= (fill_nxt == CNT_W'(STORE_LEN));
    end else if (cmd.clear) begin
      out_r.ok        <= 1'b0;
      out_r.int_value <= '0;
      out_r.is_full   <= 1'b0;
    end else if (cmd.other) begin
      out_r.ok        <= 1'b0;
      out_r.int_value <= '0;
      out_r.is_full   <= full;
    end else if (cmd.scan && term) begin
      out_r.ok        <= pass;
      out_r.int_value <= pass ? $signed(final_val) : '0;
      out_r.is_full   <= full;
    end
  end

  assign stat.term = cmd.scan && term;
  assign out_data  = out_r;

endmodule

// ===== rtl/command_word_buffer_int_parse.sv =====
// push/clear/unused codes: result the cycle after acceptance, one transaction per cycle if idle
// parse: the scan reads one stored byte per cycle from the character memory, so the result
//   comes when the target word ends or the fill_count stored bytes run out (64 in a full default store)
// busy is high only while a parse scans; the receiver cannot stall, results are strobed
// synchronous active-low reset empties the store by zeroing the fill count; no clearing pass
module command_word_buffer_int_parse #(
  parameter int STORE_LEN = cwb_pkg::STORE_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // input channel
  input  logic          start,
  output logic          busy,
  input  cwb_pkg::in_t  in_data,
  // result channel
  output logic          out_strobe,
  output cwb_pkg::out_t out_data
);

  // command and status between controller and datapath
  cwb_pkg::ctrl_cmd_t cmd;
  cwb_pkg::dp_stat_t  stat;

  // controller: idle / scan sequencing and result strobe
  cwb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .func       (in_data.func),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // datapath: character memory, fill count, word walker and decimal accumulator
  cwb_dp #(
    .STORE_LEN (STORE_LEN)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
